[src/idalloc_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the id allocator
// no dependencies; imported by idalloc_freelist and id_allocator_with_recycle_fifo
package idalloc_pkg;

  localparam int unsigned DEFAULT_FREE_DEPTH = 64;
  localparam int unsigned DEFAULT_ID_BITS    = 16;

  localparam int unsigned ID_FIELD_W   = 16;
  localparam int unsigned MODE_W       = 2;
  localparam int unsigned STATUS_W     = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_REACH   = 2'd2
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_LIST_FULL = 2'd1,
    STATUS_EXHAUSTED = 2'd2
  } status_e;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [ID_FIELD_W-1:0] id_value;
  } req_t;

  typedef struct packed {
    logic [ID_FIELD_W-1:0] id_out;
    logic [STATUS_W-1:0]   status;
    logic                  reached;
  } rsp_t;

  // free list control and status between top level and list
  typedef struct packed {
    logic push;
    logic pop;
  } fl_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fl_stat_t;

endpackage

[src/id_allocator_with_recycle_fifo.sv]
`timescale 1ns / 1ps
// id allocator: fresh counter plus fifo free list of recycled ids
// depends on idalloc_pkg and idalloc_freelist
//
//  channel   | ports                      | handshake
//  ----------+----------------------------+-------------------------------
//  request   | req_i (mode, id_value)     | taken when start && !busy
//  result    | rsp_o (id_out, status,     | done_o high one cycle, no stall
//            |        reached)            |
//  config    | cfg_wdata_i (start_id)     | written when cfg_we_i
//
// one request per cycle; busy stays low. the result of a request shows in the
// cycle after it is taken, set by the registered read of the free list
// memory at its head pointer.
// reset clears the counter to zero and empties the free list; memory
// contents are never cleared since only counted entries are read.
// the receiver cannot stall: results stream out in the cycle after their requests.
module id_allocator_with_recycle_fifo #(
  parameter int unsigned FREE_DEPTH = idalloc_pkg::DEFAULT_FREE_DEPTH,
  parameter int unsigned ID_BITS    = idalloc_pkg::DEFAULT_ID_BITS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  idalloc_pkg::req_t                  req_i,
  output logic                               done_o,
  output idalloc_pkg::rsp_t                  rsp_o,
  input  logic                               cfg_we_i,
  input  logic [idalloc_pkg::ID_FIELD_W-1:0] cfg_wdata_i
);
  import idalloc_pkg::*;

  // counter keeps one extra bit so exhaustion is seen instead of a wrap
  localparam int unsigned CntW = ID_BITS + 1;

  logic [CntW-1:0]    fresh_q, fresh_d;
  logic               accept;
  fl_ctl_t            fl_ctl;
  fl_stat_t           fl_stat;
  logic [ID_BITS-1:0] fl_rdata;

  // response stage registers
  logic                  done_q;
  logic                  from_list_q, from_list_d;
  logic [ID_FIELD_W-1:0] id_q, id_d;
  logic [STATUS_W-1:0]   status_q, status_d;
  logic                  reached_q, reached_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    fresh_d     = fresh_q;
    fl_ctl.push = 1'b0;
    fl_ctl.pop  = 1'b0;
    from_list_d = 1'b0;
    id_d        = '0;
    status_d    = STATUS_OK;
    reached_d   = 1'b0;
    if (accept) begin
      case (req_i.mode)
        MODE_ALLOC: begin
          if (!fl_stat.empty) begin
            // recycled id arrives from memory next cycle
            fl_ctl.pop  = 1'b1;
            from_list_d = 1'b1;
          end else if (!fresh_q[ID_BITS]) begin
            id_d    = ID_FIELD_W'(fresh_q);
            fresh_d = fresh_q + 1'b1;
          end else begin
            status_d = STATUS_EXHAUSTED;
          end
        end
        MODE_RELEASE: begin
          if (fl_stat.full) begin
            status_d = STATUS_LIST_FULL;
          end else begin
            fl_ctl.push = 1'b1;
          end
        end
        MODE_REACH: begin
          reached_d = fl_stat.empty && (32'(fresh_q) >= 32'(req_i.id_value));
        end
        default: begin
          // unused mode: zero result, no state change
        end
      endcase
    end
    // config write loads the counter; the user must write only while no request is in flight (not enforced here)
    if (cfg_we_i) begin
      fresh_d = CntW'(ID_BITS'(cfg_wdata_i));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q <= '0;
      done_q  <= 1'b0;
    end else begin
      fresh_q <= fresh_d;
      done_q  <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    from_list_q <= from_list_d;
    id_q        <= id_d;
    status_q    <= status_d;
    reached_q   <= reached_d;
  end

  idalloc_freelist #(
    .FreeDepth(FREE_DEPTH),
    .IdBits   (ID_BITS)
  ) u_freelist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (fl_ctl),
    .wdata_i(ID_BITS'(req_i.id_value)),
    .rdata_o(fl_rdata),
    .stat_o (fl_stat)
  );

  assign done_o         = done_q;
  assign rsp_o.id_out   = from_list_q ? ID_FIELD_W'(fl_rdata) : id_q;
  assign rsp_o.status   = status_q;
  assign rsp_o.reached  = reached_q;

  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o) else $error("accepted item produced no result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o) else $error("result without accepted item");

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q[ID_BITS] |-> (fresh_q[ID_BITS-1:0] == '0))
    else $error("fresh counter ran past the id range");

endmodule

[src/idalloc_freelist.sv]
`timescale 1ns / 1ps
// fifo free list of recycled ids: ring memory with head, tail and fill count
// depends on idalloc_pkg
module idalloc_freelist #(
  parameter int unsigned FreeDepth = idalloc_pkg::DEFAULT_FREE_DEPTH,
  parameter int unsigned IdBits    = idalloc_pkg::DEFAULT_ID_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  idalloc_pkg::fl_ctl_t ctl_i,
  input  logic [IdBits-1:0]    wdata_i,
  output logic [IdBits-1:0]    rdata_o,
  output idalloc_pkg::fl_stat_t stat_o
);
  import idalloc_pkg::*;

  localparam int unsigned PtrW = $clog2(FreeDepth);
  localparam int unsigned CntW = $clog2(FreeDepth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(FreeDepth - 1);

  logic [IdBits-1:0] mem [FreeDepth];
  logic [IdBits-1:0] rdata_q;
  logic [PtrW-1:0]   head_q, head_d, tail_q, tail_d;
  logic [CntW-1:0]   count_q, count_d;

  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == CntW'(FreeDepth));

  always_comb begin
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    if (ctl_i.pop) begin
      head_d  = (head_q == LastPtr) ? '0 : head_q + 1'b1;
      count_d = count_q - 1'b1;
    end else if (ctl_i.push) begin
      tail_d  = (tail_q == LastPtr) ? '0 : tail_q + 1'b1;
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // single write port at tail, registered read at head
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      mem[tail_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.pop) begin
      rdata_q <= mem[head_q];
    end
  end

  assign rdata_o = rdata_q;

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.pop |-> !stat_o.empty) else $error("pop from empty free list");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.push |-> !stat_o.full) else $error("push into full free list");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat_o.empty || stat_o.full) |-> (head_q == tail_q))
    else $error("free list pointers disagree with fill count");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// self-checking bench for the id allocator: directed and random requests, start_id rewrites
// depends on idalloc_pkg and id_allocator_with_recycle_fifo
module testbench;
  import idalloc_pkg::*;

  // mode value the block must ignore
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned RING_DEPTH    = 64;
  localparam int unsigned TARGET_ITEMS  = 1950;
  localparam int unsigned CALM_ITEMS    = 1750;  // past this point nobody idles
  localparam int unsigned SETTLE_CYCLES = 3;     // quiet cycles before a start_id write
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // one planned step: either a request item or a start_id write
  typedef struct {
    bit                    is_cfg;
    logic [ID_FIELD_W-1:0] cfg_value;
    req_t                  req;
    int unsigned           gap;
  } plan_step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // block inputs, known from time zero
  logic                  start = 1'b0;
  req_t                  req = '0;
  logic                  cfg_we = 1'b0;
  logic [ID_FIELD_W-1:0] cfg_wdata = '0;

  logic busy;
  logic done_o;
  rsp_t rsp_o;

  id_allocator_with_recycle_fifo u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  // stimulus plan and answers still owed by the block
  plan_step_t request_plan_q[$];
  rsp_t       pending_answers_q[$];

  // shadow allocator state
  logic [ID_FIELD_W:0]   shadow_next_id;
  logic [ID_FIELD_W-1:0] shadow_ring [RING_DEPTH];
  logic [5:0]            ring_head;
  logic [5:0]            ring_tail;
  logic [6:0]            ring_fill;

  // bookkeeping
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_planned = 0;
  int unsigned n_fresh = 0, n_recycled = 0, n_exhausted = 0;
  int unsigned n_list_full = 0, n_reach_hits = 0, n_unused = 0, n_start_writes = 0;
  bit          idle_enabled = 1'b1;
  int          plan_base = 0;  // last start_id in the plan, steers reach thresholds

  // driver scratch
  logic                  took_item;
  logic                  drive_start;
  logic                  drive_we;
  req_t                  drive_req;
  logic [ID_FIELD_W-1:0] drive_wdata;

  // -------------------------------------------------------------------------
  // shadow allocator: serves one request and returns the answer it owes
  // -------------------------------------------------------------------------
  function automatic rsp_t serve_request(req_t rq);
    rsp_t answer;
    answer = '0;
    case (rq.mode)
      MODE_ALLOC: begin
        if (ring_fill != 0) begin
          // recycled ids leave in release order
          answer.id_out = shadow_ring[ring_head];
          ring_head = ring_head + 1'b1;
          ring_fill = ring_fill - 1'b1;
          n_recycled++;
        end else if (!shadow_next_id[ID_FIELD_W]) begin
          answer.id_out = shadow_next_id[ID_FIELD_W-1:0];
          shadow_next_id = shadow_next_id + 1'b1;
          n_fresh++;
        end else begin
          // counter ran past the top id and nothing to recycle
          answer.status = STATUS_EXHAUSTED;
          n_exhausted++;
        end
      end
      MODE_RELEASE: begin
        if (ring_fill >= RING_DEPTH) begin
          // list full: id is dropped
          answer.status = STATUS_LIST_FULL;
          n_list_full++;
        end else begin
          shadow_ring[ring_tail] = rq.id_value;
          ring_tail = ring_tail + 1'b1;
          ring_fill = ring_fill + 1'b1;
        end
      end
      MODE_REACH: begin
        answer.reached = (ring_fill == 0) && (shadow_next_id >= {1'b0, rq.id_value});
        if (answer.reached) n_reach_hits++;
      end
      default: n_unused++;
    endcase
    return answer;
  endfunction

  // -------------------------------------------------------------------------
  // plan building helpers
  // -------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    if (idle_enabled && $urandom_range(0, 3) == 0) return $urandom_range(1, 6);
    return 0;
  endfunction

  task automatic plan_item(logic [MODE_W-1:0] m, logic [ID_FIELD_W-1:0] v);
    plan_step_t s;
    s.is_cfg       = 1'b0;
    s.cfg_value    = '0;
    s.req.mode     = m;
    s.req.id_value = v;
    s.gap          = pick_gap();
    request_plan_q.push_back(s);
    n_planned++;
    if (n_planned > CALM_ITEMS) idle_enabled = 1'b0;
  endtask

  task automatic plan_start_id(logic [ID_FIELD_W-1:0] v);
    plan_step_t s;
    s.is_cfg    = 1'b1;
    s.cfg_value = v;
    s.req       = '0;
    s.gap       = 0;
    request_plan_q.push_back(s);
    plan_base = int'(v);
  endtask

  // thresholds mostly land near where the counter is likely to be
  function automatic logic [ID_FIELD_W-1:0] pick_threshold();
    int unsigned r;
    int t;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 4) return ID_FIELD_W'($urandom);
    t = plan_base + int'($urandom_range(0, 80)) - 10;
    if (t < 0) t = 0;
    if (t > 65535) t = 65535;
    return ID_FIELD_W'(t);
  endfunction

  function automatic logic [ID_FIELD_W-1:0] pick_release_id();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return ID_FIELD_W'($urandom);
  endfunction

  function automatic logic [ID_FIELD_W-1:0] pick_start_id();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return '1;
      2:       return ID_FIELD_W'(65535 - $urandom_range(0, 40));
      3:       return ID_FIELD_W'($urandom_range(0, 200));
      default: return ID_FIELD_W'($urandom);
    endcase
  endfunction

  // mixed traffic; release_pct tilts toward filling or draining the list
  task automatic plan_mixed(int unsigned len, int unsigned release_pct);
    int unsigned r;
    repeat (len) begin
      r = $urandom_range(0, 99);
      if (r < release_pct) plan_item(MODE_RELEASE, pick_release_id());
      else if (r < 85) plan_item(MODE_ALLOC, ID_FIELD_W'($urandom));
      else if (r < 97) plan_item(MODE_REACH, pick_threshold());
      else plan_item(MODE_UNUSED, ID_FIELD_W'($urandom));
    end
  endtask

  // -------------------------------------------------------------------------
  // clock, reset and run limit
  // -------------------------------------------------------------------------
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles hit, %0d answers still owed",
               $time, CYCLE_LIMIT, pending_answers_q.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // driver: books what the block took at this edge, then drives the next step
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start          <= 1'b0;
      req            <= '0;
      cfg_we         <= 1'b0;
      cfg_wdata      <= '0;
      shadow_next_id = '0;
      ring_head      = '0;
      ring_tail      = '0;
      ring_fill      = '0;
      quiet_cycles   = 0;
    end else begin
      // start_id write lands: counter reloads, free list stays
      if (cfg_we) begin
        shadow_next_id = {1'b0, cfg_wdata};
        n_start_writes++;
      end
      took_item = start && !busy;
      if (took_item) pending_answers_q.push_back(serve_request(req));

      if (pending_answers_q.size() == 0 && !start && !cfg_we) quiet_cycles++;
      else quiet_cycles = 0;

      drive_start = start && !took_item;  // hold an item the block has not taken
      drive_we    = 1'b0;
      drive_req   = req;
      drive_wdata = cfg_wdata;
      if (!drive_start && request_plan_q.size() != 0) begin
        if (request_plan_q[0].gap != 0) begin
          request_plan_q[0].gap = request_plan_q[0].gap - 1;
        end else if (request_plan_q[0].is_cfg) begin
          // register writes only once the block has gone quiet
          if (quiet_cycles >= SETTLE_CYCLES) begin
            drive_we    = 1'b1;
            drive_wdata = request_plan_q[0].cfg_value;
            void'(request_plan_q.pop_front());
          end
        end else begin
          drive_start = 1'b1;
          drive_req   = request_plan_q[0].req;
          void'(request_plan_q.pop_front());
        end
      end
      start     <= drive_start;
      req       <= drive_req;
      cfg_we    <= drive_we;
      cfg_wdata <= drive_wdata;
    end
  end

  // -------------------------------------------------------------------------
  // monitor: every strobed result against the oldest owed answer
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    rsp_t owed;
    if (rst_ni && done_o) begin
      if (pending_answers_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual id_out %h status %0d reached %0d",
                 $time, rsp_o.id_out, rsp_o.status, rsp_o.reached);
        fault_count++;
      end else begin
        owed = pending_answers_q.pop_front();
        if (rsp_o.id_out !== owed.id_out) begin
          $display("%0t: id_out mismatch, expected %h actual %h",
                   $time, owed.id_out, rsp_o.id_out);
          fault_count++;
        end
        if (rsp_o.status !== owed.status) begin
          $display("%0t: status mismatch, expected %0d actual %0d",
                   $time, owed.status, rsp_o.status);
          fault_count++;
        end
        if (rsp_o.reached !== owed.reached) begin
          $display("%0t: reached mismatch, expected %0d actual %0d",
                   $time, owed.reached, rsp_o.reached);
          fault_count++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // plan the run, then wait for it to drain and judge
  // -------------------------------------------------------------------------
  initial begin
    int unsigned kind;
    int unsigned fill_len;

    // directed: empty list with counter at zero
    plan_item(MODE_REACH, '0);            // reached at threshold zero
    plan_item(MODE_REACH, '1);            // not reached at the top
    plan_item(MODE_ALLOC, '1);            // fresh 0, id_value ignored
    plan_item(MODE_ALLOC, '0);            // fresh 1
    plan_item(MODE_RELEASE, 16'hFFFF);
    plan_item(MODE_RELEASE, 16'h0000);
    plan_item(MODE_RELEASE, 16'hA5A5);
    plan_item(MODE_REACH, '0);            // list not empty, never reached
    plan_item(MODE_UNUSED, 16'hFFFF);     // ignored mode, all-zero answer
    plan_item(MODE_ALLOC, '0);            // recycled in release order
    plan_item(MODE_ALLOC, '0);
    plan_item(MODE_ALLOC, '0);
    plan_item(MODE_ALLOC, '0);            // back to fresh ids: 2
    // directed: counter at the top id, then exhaustion
    plan_start_id('1);
    plan_item(MODE_REACH, '1);            // counter equals threshold
    plan_item(MODE_ALLOC, '0);            // last fresh id
    plan_item(MODE_ALLOC, '0);            // exhausted
    plan_item(MODE_REACH, '1);            // counter past the top still reaches
    plan_item(MODE_RELEASE, 16'h5A5A);
    plan_item(MODE_ALLOC, '0);            // exhaustion does not block recycling
    plan_item(MODE_ALLOC, '0);            // exhausted again
    plan_item(MODE_UNUSED, 16'h0000);
    plan_start_id('0);
    plan_item(MODE_ALLOC, '0);

    // random phases until the item budget is spent
    while (n_planned < TARGET_ITEMS) begin
      kind = $urandom_range(0, 4);
      if (kind == 2 || $urandom_range(0, 1) == 0) begin
        if (kind == 2) plan_start_id(ID_FIELD_W'(65535 - $urandom_range(0, 30)));
        else plan_start_id(pick_start_id());
      end
      case (kind)
        0: plan_mixed($urandom_range(20, 80), 40);
        1: begin
          // fill the list to near or past its depth, probe, then try to drain it past empty
          fill_len = $urandom_range(RING_DEPTH - 4, RING_DEPTH + 6);
          repeat (fill_len) plan_item(MODE_RELEASE, pick_release_id());
          repeat ($urandom_range(0, 3)) plan_item(MODE_REACH, pick_threshold());
          repeat (fill_len + $urandom_range(0, 6)) plan_item(MODE_ALLOC, '0);
          plan_item(MODE_REACH, pick_threshold());
        end
        2: plan_mixed($urandom_range(20, 50), 10);   // run the counter out
        3: plan_mixed($urandom_range(30, 90), 65);   // lean toward a full list
        default: plan_mixed($urandom_range(10, 40), 30);
      endcase
    end

    // let everything go out and come back
    @(posedge clk_i);
    while (request_plan_q.size() != 0 || start || cfg_we || pending_answers_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_answers_q.size() != 0) begin
      $display("%0t: %0d answers never arrived, expected %0d more results actual none",
               $time, pending_answers_q.size(), pending_answers_q.size());
      fault_count++;
    end

    $display("covered %0d items: %0d fresh ids, %0d recycled, %0d exhausted, %0d list full",
             n_planned, n_fresh, n_recycled, n_exhausted, n_list_full);
    $display("  %0d reach hits, %0d ignored-mode items, %0d start_id writes, %0d faults",
             n_reach_hits, n_unused, n_start_writes, fault_count);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
